FILE: sv/swm_pkg.sv
// shared constants and types for the sliding window maximum block
package swm_pkg;

  // default sizes, handed to the top level parameters
  localparam int unsigned WINDOW_MAX_DEF   = 32;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;

  // configuration register file
  localparam int unsigned CFG_W            = 6;
  localparam int unsigned PADDR_W          = 2;
  localparam int unsigned PDATA_W          = 32;
  localparam logic [PADDR_W-1:0] ADDR_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_W-1:0]   WINDOW_SIZE_RST  = 6'd3;
  localparam logic [CFG_W-1:0]   SEEN_SAT         = '1;

  // per-transaction control broadcast to every cell
  typedef struct packed {
    logic             step;         // shift the chain and take the new sample
    logic             clear;        // drop all candidates without shifting
    logic             first;        // start of a new sequence
    logic [CFG_W-1:0] window_size;  // current window length
  } swm_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_DELIVER
  } swm_state_e;

endpackage

FILE: sv/swm_cell.sv
// one cell of the sample chain: holds the sample of a fixed age and its candidate flag
module swm_cell
  import swm_pkg::*;
#(
  parameter int unsigned SampleWidth = SAMPLE_WIDTH_DEF,
  parameter int unsigned CellIndex   = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  swm_ctrl_t              ctrl_i,
  input  logic [SampleWidth-1:0] sample_i,
  input  logic [SampleWidth-1:0] prev_val_i,
  input  logic                   prev_cand_i,
  output logic [SampleWidth-1:0] val_o,
  output logic                   cand_o
);

  logic [SampleWidth-1:0] val_q;
  logic                   cand_q;
  logic                   cand_d;
  logic                   greater;
  logic                   in_window;

  // an older sample stays a candidate only while it beats every newer one
  assign greater   = $signed(prev_val_i) > $signed(sample_i);
  assign in_window = 32'(ctrl_i.window_size) > 32'(CellIndex);
  assign cand_d    = (CellIndex == 0) ? prev_cand_i
                   : (prev_cand_i & ~ctrl_i.first & greater & in_window);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= 1'b0;
    end else if (ctrl_i.step) begin
      cand_q <= cand_d;
    end else if (ctrl_i.clear) begin
      cand_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      val_q <= prev_val_i;
    end
  end

  assign val_o  = val_q;
  assign cand_o = cand_q;

endmodule

FILE: sv/swm_front.sv
// registered tree that picks the oldest candidate of the chain
module swm_front
  import swm_pkg::*;
#(
  parameter int unsigned WindowMax   = WINDOW_MAX_DEF,
  parameter int unsigned SampleWidth = SAMPLE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [WindowMax-1:0]   cand_i,
  input  logic [SampleWidth-1:0] val_i [WindowMax],
  output logic [SampleWidth-1:0] front_o
);

  localparam int unsigned Leaves = 1 << $clog2(WindowMax);

  // heap order: node n has children 2n (younger half) and 2n+1 (older half)
  logic [SampleWidth-1:0] tree_val [1:2*Leaves-1];
  logic                   tree_vld [1:2*Leaves-1];

  for (genvar i = 0; i < Leaves; i++) begin : g_leaf
    if (i < WindowMax) begin : g_real
      assign tree_val[Leaves+i] = val_i[i];
      assign tree_vld[Leaves+i] = cand_i[i];
    end else begin : g_pad
      assign tree_val[Leaves+i] = '0;
      assign tree_vld[Leaves+i] = 1'b0;
    end
  end

  for (genvar n = 1; n < Leaves; n++) begin : g_node
    logic [SampleWidth-1:0] val_q;
    logic                   vld_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= tree_vld[2*n] | tree_vld[2*n+1];
      end
    end

    // older side wins whenever it holds a candidate
    always_ff @(posedge clk_i) begin
      val_q <= tree_vld[2*n+1] ? tree_val[2*n+1] : tree_val[2*n];
    end

    assign tree_val[n] = val_q;
    assign tree_vld[n] = vld_q;
  end

  assign front_o = tree_val[1];

endmodule

FILE: sv/sliding_window_max.sv
// top level of the sliding window maximum filter
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_stall_o   sample_i, first_i
//   output    out        out_valid_o / out_stall_i window_max_o
//   config    in/out     apb psel/penable/pready   paddr, pwdata, prdata
//
// a transaction goes into the cell chain; one that gives a result then waits in the
// settle state for the front-select tree and in the deliver state to load the output
// register, while one without a result leaves the sample input free
// reset clears the candidate flags, the seen count and the state machine; the
// window length register resets to 3
// a stalled output holds its result while the next sample is already taken in
module sliding_window_max
  import swm_pkg::*;
#(
  parameter int unsigned WindowMax   = WINDOW_MAX_DEF,
  parameter int unsigned SampleWidth = SAMPLE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // sample stream
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SampleWidth-1:0] sample_i,
  input  logic                   first_i,
  // result stream
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SampleWidth-1:0] window_max_o,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  // tree latency and counter widths
  localparam int unsigned TreeDepth = $clog2(WindowMax);
  localparam int unsigned DepthW    = (TreeDepth > 0) ? $clog2(TreeDepth + 1) : 1;
  localparam int unsigned SizeBits  = $clog2(WindowMax + 1);
  localparam int unsigned CntW      = (SizeBits > CFG_W) ? SizeBits : CFG_W;

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] window_size_q;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready & (paddr == ADDR_WINDOW_SIZE);
  assign prdata    = (paddr == ADDR_WINDOW_SIZE) ? PDATA_W'(window_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_SIZE_RST;
    end else if (cfg_write) begin
      window_size_q <= pwdata[CFG_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // transaction control and seen count
  // ---------------------------------------------------------------------------
  swm_state_e      state_q, state_d;
  logic [DepthW-1:0] wait_q, wait_d;
  logic [CFG_W-1:0]  seen_q, seen_d;
  logic [CFG_W-1:0]  seen_base, seen_inc;
  logic [CntW-1:0]   size_ext, size_eff;
  logic              size_nz;
  logic              in_accept;
  logic              emit;
  logic              load_out;
  swm_ctrl_t         ctrl;

  assign in_accept = in_valid_i & ~in_stall_o;
  assign size_nz   = (window_size_q != '0);

  // lengths above the chain depth act as the full chain
  assign size_ext = CntW'(window_size_q);
  assign size_eff = (size_ext > CntW'(WindowMax)) ? CntW'(WindowMax) : size_ext;

  // seen count restarts on a sequence mark and saturates
  assign seen_base = first_i ? '0 : seen_q;
  assign seen_inc  = (seen_base == SEEN_SAT) ? seen_base : seen_base + 1'b1;
  assign emit      = size_nz & (CntW'(seen_inc) >= size_eff);
  assign seen_d    = !in_accept ? seen_q : (size_nz ? seen_inc : seen_base);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

  // a zero window leaves the chain alone, apart from the clear of a sequence mark
  assign ctrl.step        = in_accept & size_nz;
  assign ctrl.clear       = in_accept & first_i & ~size_nz;
  assign ctrl.first       = first_i;
  assign ctrl.window_size = window_size_q;

  // ---------------------------------------------------------------------------
  // state machine: settle the tree, then hand the front to the output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wait_q  <= '0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    wait_d     = wait_q;
    load_out   = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && emit) begin
          if (TreeDepth == 0) begin
            state_d = ST_DELIVER;
          end else begin
            state_d = ST_SETTLE;
            wait_d  = DepthW'(TreeDepth);
          end
        end
      end
      ST_SETTLE: begin
        wait_d = wait_q - 1'b1;
        if (wait_q == DepthW'(1)) begin
          state_d = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        // wait until the output register is free or being emptied
        if (!out_valid_o || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // cell chain: cell k holds the sample of age k
  // ---------------------------------------------------------------------------
  logic [SampleWidth-1:0] cell_val [WindowMax];
  logic [WindowMax-1:0]   cell_cand;

  for (genvar k = 0; k < WindowMax; k++) begin : g_cell
    logic [SampleWidth-1:0] prev_val;
    logic                   prev_cand;

    if (k == 0) begin : g_head
      // the new sample always joins as the youngest candidate
      assign prev_val  = sample_i;
      assign prev_cand = 1'b1;
    end else begin : g_body
      assign prev_val  = cell_val[k-1];
      assign prev_cand = cell_cand[k-1];
    end

    swm_cell #(
      .SampleWidth (SampleWidth),
      .CellIndex   (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .sample_i    (sample_i),
      .prev_val_i  (prev_val),
      .prev_cand_i (prev_cand),
      .val_o       (cell_val[k]),
      .cand_o      (cell_cand[k])
    );
  end

  // front of the queue is the oldest surviving candidate
  logic [SampleWidth-1:0] front;

  swm_front #(
    .WindowMax   (WindowMax),
    .SampleWidth (SampleWidth)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cand_i  (cell_cand),
    .val_i   (cell_val),
    .front_o (front)
  );

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic                   out_valid_q;
  logic [SampleWidth-1:0] out_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_max_q <= front;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = out_max_q;

endmodule

FILE: tb/sv/tb_sliding_window_max.sv
// self-checking testbench for the sliding window maximum filter
module tb_sliding_window_max
  import swm_pkg::*;
();

  localparam int unsigned WIN           = WINDOW_MAX_DEF;
  localparam int unsigned SW            = SAMPLE_WIDTH_DEF;
  // time from sample in to result register when the output does not stall
  localparam int unsigned RESULT_LAT    = $clog2(WIN) + 2;
  // quiet cycles after the last result before a register write
  localparam int unsigned SETTLE_CYCLES = 2 * RESULT_LAT + 4;
  localparam int unsigned HOLD_CYCLES   = 300;
  // no transaction for this long means the block is hung
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned AGE_SAT       = 63;
  localparam int unsigned PHASE_ITEMS   = 115;
  localparam int unsigned ERR_SHOWN     = 10;

  // value patterns for a well-formed sequence
  typedef enum int {
    PAT_RANDOM,
    PAT_FALLING,
    PAT_RISING,
    PAT_NARROW,
    PAT_EXTREME
  } pattern_e;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [SW-1:0]          sample_i    = '0;
  logic                   first_i     = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [SW-1:0]          window_max_o;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [PADDR_W-1:0]     paddr       = '0;
  logic [PDATA_W-1:0]     pwdata      = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  sliding_window_max dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the candidate queue, front at index 0
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0]   cand_val [WIN];
  logic [CFG_W-1:0]       cand_age [WIN];
  int unsigned            live_cnt = 0;
  int unsigned            seen_cnt = 0;
  logic [CFG_W-1:0]       win_reg  = WINDOW_SIZE_RST;

  // window maxima the block owes us, oldest first
  logic signed [SW-1:0]   pending_max [$];
  logic signed [SW-1:0]   owed_max;

  int unsigned            mismatches         = 0;
  int unsigned            items_sent         = 0;
  int unsigned            maxima_checked     = 0;
  int unsigned            settings_used      = 0;
  int unsigned            input_stall_cycles = 0;
  int unsigned            idle_cycles        = 0;
  int unsigned            hold_request       = 0;
  int unsigned            hold_left          = 0;
  // turns off random idling on both channels
  bit                     quiet              = 1'b0;

  function automatic void shift_out_front(input int unsigned n);
    for (int unsigned i = 0; i + n < live_cnt; i++) begin
      cand_val[i] = cand_val[i + n];
      cand_age[i] = cand_age[i + n];
    end
    live_cnt -= n;
  endfunction

  // advance the shadow queue by one sample; returns 1 when a maximum is due
  function automatic bit window_max_step(input logic signed [SW-1:0] s, input logic fst,
                                         output logic signed [SW-1:0] wmax);
    int unsigned span;
    int unsigned stale;
    wmax = '0;
    if (fst) begin
      live_cnt = 0;
      seen_cnt = 0;
    end
    // oversized windows behave like the full queue depth
    span = (win_reg > WIN) ? WIN : win_reg;
    // zero window: the sample is ignored apart from its start mark
    if (span == 0) return 1'b0;
    for (int unsigned i = 0; i < live_cnt; i++) begin
      if (cand_age[i] < AGE_SAT) cand_age[i]++;
    end
    // back of the queue: anything not greater than the new sample can never win
    while (live_cnt > 0 && cand_val[live_cnt - 1] <= s) live_cnt--;
    // front of the queue: candidates that slid out of the window
    stale = 0;
    while (stale < live_cnt && cand_age[stale] >= span) stale++;
    shift_out_front(stale);
    // guard for a full queue, should never trigger
    if (live_cnt >= WIN) shift_out_front(1);
    cand_val[live_cnt] = s;
    cand_age[live_cnt] = '0;
    live_cnt++;
    if (seen_cnt < SEEN_SAT) seen_cnt++;
    if (seen_cnt < span) return 1'b0;
    wmax = cand_val[0];
    return 1'b1;
  endfunction

  task automatic note_error(input string what, input string exp_s, input int act);
    mismatches++;
    if (mismatches <= ERR_SHOWN) begin
      $display("mismatch at %0t: %s expected %s got %0d", $time, what, exp_s, act);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sample side: one transaction per call, random gaps unless quiet
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic signed [SW-1:0] s, input logic fst);
    logic signed [SW-1:0] wmax;
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    first_i    <= fst;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (window_max_step(s, fst, wmax)) pending_max.insert(pending_max.size(), wmax);
  endtask

  function automatic logic signed [SW-1:0] next_sample(input pattern_e pat,
                                                        input logic signed [SW-1:0] prev);
    int p;
    p = prev;
    case (pat)
      PAT_FALLING: begin
        // long runs of shrinking values fill the queue deep
        p = (p < -32000) ? 32767 - int'($urandom_range(0, 3)) : p - int'($urandom_range(0, 700));
      end
      PAT_RISING: begin
        p = (p > 32000) ? -32768 + int'($urandom_range(0, 3)) : p + int'($urandom_range(0, 700));
      end
      PAT_NARROW: begin
        // many equal values, exercises the not-greater drop
        p = int'($urandom_range(0, 6)) - 3;
      end
      PAT_EXTREME: begin
        case ($urandom_range(3))
          0:       p = -32768;
          1:       p = 32767;
          2:       p = 0;
          default: p = -1;
        endcase
      end
      default: begin
        p = int'($urandom);
      end
    endcase
    return p[SW-1:0];
  endfunction

  // a sequence with an optional start mark and some stray marks as noise
  task automatic send_sequence(input int unsigned len, input pattern_e pat, input bit mark);
    logic signed [SW-1:0] v;
    v = SW'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      v = next_sample(pat, v);
      send_sample(v, (i == 0 && mark) || ($urandom_range(39) == 0));
    end
  endtask

  // sender pause: stop offering and let every owed maximum come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_max.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // configuration port, setup then access phase
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input int unsigned ws);
    logic [PDATA_W-1:0] data;
    data = $urandom;
    data[CFG_W-1:0] = ws[CFG_W-1:0];
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_WINDOW_SIZE;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    win_reg = data[CFG_W-1:0];
    settings_used++;
    @(posedge clk_i);
  endtask

  task automatic cfg_check_readback();
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= ADDR_WINDOW_SIZE;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CFG_W-1:0] !== win_reg) begin
      note_error("window_size readback", $sformatf("%0d", win_reg), int'(prdata[CFG_W-1:0]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall, long hold on request, in-order compare
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_max.size() == 0) begin
        note_error("unexpected window_max", "nothing", $signed(window_max_o));
      end else begin
        owed_max = pending_max[0];
        pending_max.delete(0);
        maxima_checked++;
        if (window_max_o !== owed_max) begin
          note_error("window_max", $sformatf("%0d", owed_max), $signed(window_max_o));
        end
      end
    end
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 13);
    end
  end

  // watchdog: any transaction on any port counts as progress
  always @(posedge clk_i) begin
    if (in_valid_i && in_stall_o) input_stall_cycles++;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d maxima owed",
               idle_cycles, pending_max.size());
      $display("tb_sliding_window_max: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset value, both extremes, upper data bits random
  task automatic test_register_access();
    cfg_check_readback();
    cfg_write(0);
    cfg_check_readback();
    cfg_write(63);
    cfg_check_readback();
    cfg_write(WINDOW_SIZE_RST);
    cfg_check_readback();
  endtask

  // sample extremes, equal values, a start mark in the middle, window of three
  task automatic test_extremes();
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    wait_drained();
  endtask

  task automatic test_window_special();
    // zero window: nothing comes out, only the start mark acts
    cfg_write(0);
    send_sample(16'sd5, 1'b1);
    send_sample(-16'sd7, 1'b0);
    wait_drained();
    // one-sample window gives every sample back
    cfg_write(1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd1, 1'b0);
    wait_drained();
    // falling run, then the window shrinks without a new start mark
    cfg_write(4);
    send_sample(16'sd10, 1'b1);
    send_sample(16'sd9, 1'b0);
    send_sample(16'sd8, 1'b0);
    send_sample(16'sd7, 1'b0);
    wait_drained();
    cfg_write(2);
    send_sample(16'sd6, 1'b0);
    send_sample(16'sd20, 1'b0);
    wait_drained();
    // oversized window clamps to the queue depth
    cfg_write(33);
    send_sample(-16'sd3, 1'b1);
    send_sample(16'sd4, 1'b0);
    wait_drained();
  endtask

  task automatic test_zero_window();
    cfg_write(0);
    send_sequence(40, PAT_RANDOM, 1'b1);
    wait_drained();
  endtask

  task automatic run_phase(input int unsigned ws, input int unsigned n_items);
    int unsigned left;
    int unsigned len;
    int unsigned span;
    pattern_e    pat;
    bit          mark;
    wait_drained();
    cfg_write(ws);
    span = (ws > WIN) ? WIN : ws;
    left = n_items;
    while (left > 0) begin
      // mostly a few windows long, sometimes long enough to saturate the seen count
      if ($urandom_range(9) < 7) len = $urandom_range(1, 2 * span + 4);
      else len = $urandom_range(span, 100);
      if (len > left) len = left;
      pat = pattern_e'($urandom_range(int'(PAT_EXTREME)));
      // the first sequence of a phase may carry on the old one under the new window
      mark = (left == n_items) ? bit'($urandom_range(1)) : ($urandom_range(9) != 0);
      send_sequence(len, pat, mark);
      left -= len;
    end
  endtask

  task automatic test_random_windows();
    int unsigned sizes [13];
    sizes = '{1, 2, 3, 4, 5, 7, 8, 16, 31, 32, 33, 63, 0};
    sizes[12] = $urandom_range(1, 63);
    foreach (sizes[k]) begin
      // one phase runs flat out on both channels
      quiet = (k == 6);
      run_phase(sizes[k], PHASE_ITEMS);
      quiet = 1'b0;
    end
    wait_drained();
  endtask

  // long output hold while samples keep coming, the block has to push back
  task automatic test_backpressure();
    cfg_write(2);
    quiet = 1'b1;
    hold_request = HOLD_CYCLES;
    send_sequence(150, PAT_RANDOM, 1'b1);
    quiet = 1'b0;
    wait_drained();
  endtask

  // sender stops mid-sequence until everything is out, then carries on
  task automatic test_sender_pause();
    cfg_write(5);
    send_sequence(20, PAT_RANDOM, 1'b1);
    wait_drained();
    send_sequence(20, PAT_FALLING, 1'b0);
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_access();
    test_extremes();
    test_window_special();
    test_zero_window();
    test_random_windows();
    test_backpressure();
    test_sender_pause();
    wait_drained();
    $display("sent %0d samples, checked %0d window maxima over %0d window settings",
             items_sent, maxima_checked, settings_used);
    $display("input held off for %0d cycles, %0d mismatches", input_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("tb_sliding_window_max: PASS");
    end else begin
      $display("tb_sliding_window_max: FAIL");
    end
    $finish;
  end

endmodule
